// ===== sv/tqi_pkg.sv =====
// Package for the table quadratic interpolator: shared types and codes.
// No dependencies.
package tqi_pkg;

  localparam int unsigned RowsCfgWidth = 7;
  localparam int unsigned ColsCfgWidth = 4;
  localparam int unsigned RowWidth = 6;
  localparam int unsigned ColWidth = 3;
  localparam int unsigned FracBits = 16;

  localparam logic CfgIdxRows = 1'b0;
  localparam logic CfgIdxCols = 1'b1;

  localparam logic ActWrite = 1'b0;
  localparam logic ActQuery = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StScanRd,
    StScan,
    StNodeRd,
    StNode,
    StWeight,
    StDiv,
    StMul,
    StColRd,
    StTerm,
    StEmit
  } state_e;

endpackage

// ===== sv/tqi_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module tqi_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== sv/table_quadratic_interpolator_unit.sv =====
// Top level of the table quadratic interpolator.
// Depends on tqi_pkg and tqi_ram.
//
// The table (MAX_ROWS x MAX_COLS Q16.16 entries, entry (r,c) at r*MAX_COLS+c)
// lives in one single-port RAM with a registered read. A write beat (action
// 0) stores one entry and gives no result. A query beat (action 1) first
// scans column 0 of rows 0..rows_in_use-1, one row at a time (address, then
// compare), keeping the first nearest abscissa; the row is clamped to
// [1, rows_in_use-2] as the scan ends. The three node abscissas are read, and
// the three Lagrange weights are formed by one shared restoring divider (one
// quotient bit per cycle, six ratios) and one shared multiplier. Each data
// column then takes three RAM reads and three multiply-accumulates and leaves
// as one result beat; the final column has last set. Equal node abscissas
// give 0 with div_error on every result and skip the divisions. Query time is
// set by the scan through the single RAM port and the bit-serial divider. The
// table is undefined until written; there is no clearing pass. Configuration
// writes are taken at any time and must only be issued while the block is
// idle.
module table_quadratic_interpolator_unit #(
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned MAX_COLS    = 8,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic                    cfg_index_i,
  input  logic [31:0]             cfg_data_i,
  // input items
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    action_i,
  input  logic [5:0]              row_i,
  input  logic [2:0]              column_i,
  input  logic signed [31:0]      entry_value_i,
  input  logic signed [31:0]      query_point_i,
  // result items
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2:0]              out_column_o,
  output logic signed [31:0]      out_value_o,
  output logic                    last_o,
  output logic                    div_error_o
);

  localparam int unsigned Depth = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned VW    = VALUE_WIDTH;
  // Ratio numerator (x-a)*2^16 and denominators fit in these widths.
  localparam int unsigned DW    = VW + 1;
  localparam int unsigned NW    = VW + 1 + tqi_pkg::FracBits;
  localparam int unsigned PW    = 2 * VW;
  localparam int unsigned NRW   = RW + 1;
  localparam int unsigned NCW   = CW + 1;

  localparam logic signed [VW-1:0] VMax = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMin = {1'b1, {(VW-1){1'b0}}};

  // ---------------------------------------------------------------- config
  logic [tqi_pkg::RowsCfgWidth-1:0] rows_cfg_q;
  logic [tqi_pkg::ColsCfgWidth-1:0] cols_cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= tqi_pkg::RowsCfgWidth'(3);
      cols_cfg_q <= tqi_pkg::ColsCfgWidth'(2);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tqi_pkg::CfgIdxRows: rows_cfg_q <= cfg_data_i[tqi_pkg::RowsCfgWidth-1:0];
        tqi_pkg::CfgIdxCols: cols_cfg_q <= cfg_data_i[tqi_pkg::ColsCfgWidth-1:0];
        default: ;
      endcase
    end
  end

  // Saturated counts in use by a query.
  logic [NRW-1:0] nr;
  logic [NCW-1:0] nc;
  always_comb begin
    if (32'(rows_cfg_q) < 32'd3) nr = NRW'(3);
    else if (32'(rows_cfg_q) > 32'(MAX_ROWS)) nr = NRW'(MAX_ROWS);
    else nr = NRW'(rows_cfg_q);
    if (32'(cols_cfg_q) < 32'd2) nc = NCW'(2);
    else if (32'(cols_cfg_q) > 32'(MAX_COLS)) nc = NCW'(MAX_COLS);
    else nc = NCW'(cols_cfg_q);
  end

  // ---------------------------------------------------------------- memory
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [VW-1:0]   ram_wdata;
  logic [VW-1:0]   ram_rdata;

  tqi_ram #(.Width(VW), .Depth(Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  function automatic logic [AW-1:0] ent_addr(logic [RW-1:0] r, logic [CW-1:0] c);
    logic [AW+CW-1:0] a;
    a = (AW+CW)'(r) * (AW+CW)'(MAX_COLS) + (AW+CW)'(c);
    return a[AW-1:0];
  endfunction

  function automatic logic signed [VW-1:0] sat_v(logic signed [PW+1:0] v);
    if (v > (PW+2)'(VMax)) return VMax;
    if (v < (PW+2)'(VMin)) return VMin;
    return v[VW-1:0];
  endfunction

  // ---------------------------------------------------------------- state
  tqi_pkg::state_e state_q, state_d;

  logic signed [VW-1:0] x_q;
  logic [NRW-1:0]       scan_q;       // row counter for scan
  logic [VW:0]          bestd_q;
  logic [RW-1:0]        best_q;
  logic                 have_q;
  logic signed [VW-1:0] xn_q [3];     // node abscissas
  logic signed [VW-1:0] w_q [3];      // weights
  logic signed [VW-1:0] q1_q;
  logic [1:0]           k_q;          // node index
  logic                 half_q;       // 0: q1, 1: q2
  logic                 err_q;
  logic [NCW-1:0]       col_q;
  logic signed [PW+1:0] acc_q;

  // divider
  logic [NW-1:0]        dnum_q;       // |numerator|, shifted out
  logic [DW-1:0]        dden_q;
  logic [NW:0]          drem_q;
  logic [NW-1:0]        dquo_q;
  logic                 dneg_q;
  logic [$clog2(NW+1)-1:0] dcnt_q;

  // output register
  logic                 ovalid_q;
  logic [2:0]           ocol_q;
  logic signed [31:0]   oval_q;
  logic                 olast_q;
  logic                 oerr_q;

  // write holding
  logic [RW-1:0]        wrow_q;
  logic [CW-1:0]        wcol_q;
  logic [VW-1:0]        wval_q;
  logic                 wpend_q;

  assign out_valid_o  = ovalid_q;
  assign out_column_o = ocol_q;
  assign out_value_o  = oval_q;
  assign last_o       = olast_q;
  assign div_error_o  = oerr_q;

  assign in_ready_o = (state_q == tqi_pkg::StIdle) && !wpend_q;
  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // Node row of index k relative to the clamped center.
  logic [RW-1:0] node_row [3];
  assign node_row[0] = best_q - RW'(1);
  assign node_row[1] = best_q;
  assign node_row[2] = best_q + RW'(1);

  // Other two nodes for weight k.
  logic signed [VW-1:0] nc_v, na_v, nb_v;
  always_comb begin
    case (k_q)
      2'd0: begin nc_v = xn_q[0]; na_v = xn_q[1]; nb_v = xn_q[2]; end
      2'd1: begin nc_v = xn_q[1]; na_v = xn_q[0]; nb_v = xn_q[2]; end
      default: begin nc_v = xn_q[2]; na_v = xn_q[0]; nb_v = xn_q[1]; end
    endcase
  end

  // Ratio operands.
  logic signed [DW-1:0] rnum, rden;
  assign rnum = DW'(x_q) - DW'(half_q ? nb_v : na_v);
  assign rden = DW'(nc_v) - DW'(half_q ? nb_v : na_v);

  // Scan distance; first strictly nearer row wins.
  logic signed [DW-1:0] sd;
  logic [VW:0]          sabs;
  logic                 snear;
  logic [RW-1:0]        scan_best;
  assign sd        = DW'($signed(ram_rdata)) - DW'(x_q);
  assign sabs      = sd[DW-1] ? DW'(0) - sd : sd;
  assign snear     = !have_q || sabs < bestd_q;
  assign scan_best = snear ? scan_q[RW-1:0] : best_q;

  // Divider step and result.
  logic [NW:0] drem_sh;
  logic [NW:0] drem_sub;
  assign drem_sh  = {drem_q[NW-1:0], dnum_q[NW-1]};
  assign drem_sub = drem_sh - (NW+1)'(dden_q);

  logic signed [NW:0]   dq_signed;
  logic signed [PW+1:0] dq_wide;
  assign dq_signed = dneg_q ? -$signed({1'b0, dquo_q}) : $signed({1'b0, dquo_q});
  assign dq_wide   = (PW+2)'(dq_signed);

  // Shared multiplier (registered after via acc/weights).
  logic signed [VW-1:0] ma, mb;
  logic signed [PW-1:0] mprod;
  assign mprod = ma * mb;
  logic signed [PW+1:0] mfloor;
  assign mfloor = (PW+2)'(mprod >>> tqi_pkg::FracBits);

  always_comb begin
    ma = q1_q;
    mb = w_q[k_q];
    if (state_q == tqi_pkg::StTerm) begin
      ma = w_q[k_q];
      mb = $signed(ram_rdata);
    end
  end

  // RAM port mux.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = wval_q;
    ram_addr  = ent_addr(wrow_q, wcol_q);
    case (state_q)
      tqi_pkg::StScanRd: ram_addr = ent_addr(scan_q[RW-1:0], '0);
      tqi_pkg::StScan:   ram_addr = ent_addr(scan_q[RW-1:0], '0);
      tqi_pkg::StNodeRd: ram_addr = ent_addr(node_row[k_q], '0);
      tqi_pkg::StNode:   ram_addr = ent_addr(node_row[k_q], '0);
      tqi_pkg::StColRd:  ram_addr = ent_addr(node_row[k_q], col_q[CW-1:0]);
      tqi_pkg::StTerm:   ram_addr = ent_addr(node_row[k_q], col_q[CW-1:0]);
      default:           ram_we = wpend_q;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tqi_pkg::StIdle:
        if (in_acc && action_i == tqi_pkg::ActQuery) state_d = tqi_pkg::StScanRd;
      tqi_pkg::StScanRd: state_d = tqi_pkg::StScan;
      tqi_pkg::StScan:
        if (scan_q == nr - NRW'(1)) state_d = tqi_pkg::StNodeRd;
        else state_d = tqi_pkg::StScanRd;
      tqi_pkg::StNodeRd: state_d = tqi_pkg::StNode;
      tqi_pkg::StNode:
        if (k_q == 2'd2) state_d = tqi_pkg::StWeight;
        else state_d = tqi_pkg::StNodeRd;
      tqi_pkg::StWeight:
        if (err_q) state_d = tqi_pkg::StColRd;
        else state_d = tqi_pkg::StDiv;
      tqi_pkg::StDiv:
        if (dcnt_q == '0) state_d = half_q ? tqi_pkg::StMul : tqi_pkg::StWeight;
      tqi_pkg::StMul:
        if (k_q == 2'd2) state_d = tqi_pkg::StColRd;
        else state_d = tqi_pkg::StWeight;
      tqi_pkg::StColRd: state_d = tqi_pkg::StTerm;
      tqi_pkg::StTerm:
        if (k_q == 2'd2) state_d = tqi_pkg::StEmit;
        else state_d = tqi_pkg::StColRd;
      tqi_pkg::StEmit:
        if (!ovalid_q || out_ready_i) begin
          state_d = (col_q == nc - NCW'(1)) ? tqi_pkg::StIdle : tqi_pkg::StColRd;
        end
      default: state_d = tqi_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tqi_pkg::StIdle;
      ovalid_q <= 1'b0;
      wpend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == tqi_pkg::StEmit && (!ovalid_q || out_ready_i)) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
      if (in_acc && action_i == tqi_pkg::ActWrite) wpend_q <= 1'b1;
      else if (state_q == tqi_pkg::StIdle) wpend_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      wrow_q  <= RW'(row_i);
      wcol_q  <= CW'(column_i);
      wval_q  <= VW'(entry_value_i);
      x_q     <= VW'(query_point_i);
      scan_q  <= '0;
      have_q  <= 1'b0;
      best_q  <= '0;
      k_q     <= '0;
      half_q  <= 1'b0;
    end
    case (state_q)
      tqi_pkg::StScan: begin
        if (snear) bestd_q <= sabs;
        have_q <= 1'b1;
        // clamp as the last row is compared, before the node reads
        if (scan_q == nr - NRW'(1)) begin
          if (scan_best == '0) best_q <= RW'(1);
          else if (NRW'(scan_best) > nr - NRW'(2)) best_q <= RW'(nr - NRW'(2));
          else best_q <= scan_best;
        end else begin
          best_q <= scan_best;
        end
        scan_q <= scan_q + NRW'(1);
      end
      tqi_pkg::StNode: begin
        xn_q[k_q] <= $signed(ram_rdata);
        if (k_q == 2'd2) begin
          err_q <= (xn_q[0] == xn_q[1]) || (xn_q[0] == $signed(ram_rdata)) ||
                   (xn_q[1] == $signed(ram_rdata));
          k_q   <= '0;
          half_q <= 1'b0;
          col_q <= NCW'(1);
        end else begin
          k_q <= k_q + 2'd1;
        end
      end
      tqi_pkg::StWeight: begin
        dnum_q <= NW'(rnum[DW-1] ? -rnum : rnum) << tqi_pkg::FracBits;
        dden_q <= rden[DW-1] ? DW'(-rden) : DW'(rden);
        dneg_q <= rnum[DW-1] ^ rden[DW-1];
        drem_q <= '0;
        dquo_q <= '0;
        dcnt_q <= ($clog2(NW+1))'(NW);
        if (err_q) begin
          k_q   <= '0;
          acc_q <= '0;
        end
      end
      tqi_pkg::StDiv: begin
        if (dcnt_q != '0) begin
          dnum_q <= dnum_q << 1;
          if (!drem_sub[NW]) begin
            drem_q <= drem_sub;
            dquo_q <= {dquo_q[NW-2:0], 1'b1};
          end else begin
            drem_q <= drem_sh;
            dquo_q <= {dquo_q[NW-2:0], 1'b0};
          end
          dcnt_q <= dcnt_q - 1'b1;
        end else if (!half_q) begin
          q1_q   <= sat_v(dq_wide);
          half_q <= 1'b1;
        end else begin
          w_q[k_q] <= sat_v(dq_wide);
          half_q   <= 1'b0;
        end
      end
      tqi_pkg::StMul: begin
        // w = sat(floor(q1*q2 / 2^16)); q2 sits in w_q[k]
        w_q[k_q] <= sat_v(mfloor);
        if (k_q == 2'd2) begin
          k_q   <= '0;
          acc_q <= '0;
        end else begin
          k_q <= k_q + 2'd1;
        end
      end
      tqi_pkg::StTerm: begin
        if (!err_q) acc_q <= acc_q + mfloor;
        k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
      end
      tqi_pkg::StEmit: begin
        if (!ovalid_q || out_ready_i) begin
          ocol_q  <= 3'(col_q);
          oval_q  <= 32'(err_q ? VW'(0) : sat_v(acc_q));
          olast_q <= (col_q == nc - NCW'(1));
          oerr_q  <= err_q;
          col_q   <= col_q + NCW'(1);
          acc_q   <= '0;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != tqi_pkg::StIdle) |-> !in_ready_o)
    else $error("input accepted during query");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tqi_pkg::StTerm) |-> (32'(best_q) >= 1 && NRW'(best_q) <= nr - NRW'(2)))
    else $error("center row out of clamp range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_ready_i) |=> ovalid_q)
    else $error("result dropped");

endmodule

// ===== tb/sv/table_quadratic_interpolator_unit_tb.sv =====
// Testbench for table_quadratic_interpolator_unit: table writes, nearest-node queries,
// Lagrange predictions checked per result beat. Depends on tqi_pkg and the RTL top.
// Standalone: no files, no plusargs; stimulus from $urandom.
module table_quadratic_interpolator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRows = 64;
  localparam int NumCols = 8;
  localparam longint ValMax = 64'sd2147483647;
  localparam longint ValMin = -64'sd2147483648;

  typedef struct packed {
    logic [2:0]         col;
    logic signed [31:0] val;
    logic               last;
    logic               err;
  } interp_beat_t;

  // Keeps the table image and register copies, computes the result beats of
  // each accepted query, and checks them in order as they leave the block.
  class lagrange_predictor;
    longint             tbl[NumRows*NumCols];
    bit                 written[NumRows*NumCols];
    logic [6:0]         rows_reg = 7'd3;
    logic [3:0]         cols_reg = 4'd2;
    interp_beat_t       awaited[$];
    int                 errors = 0;
    int                 beats_seen = 0;
    int                 div_err_seen = 0;

    function int eff_rows();
      int n;
      n = rows_reg;
      if (n < 3) n = 3;
      if (n > NumRows) n = NumRows;
      return n;
    endfunction

    function int eff_cols();
      int n;
      n = cols_reg;
      if (n < 2) n = 2;
      if (n > NumCols) n = NumCols;
      return n;
    endfunction

    function void set_reg(logic idx, logic [31:0] d);
      if (idx == tqi_pkg::CfgIdxRows) rows_reg = d[6:0];
      else cols_reg = d[3:0];
    endfunction

    function longint sat(longint v);
      if (v > ValMax) return ValMax;
      if (v < ValMin) return ValMin;
      return v;
    endfunction

    function longint lweight(longint x, longint c, longint a, longint b);
      longint q1, q2;
      q1 = sat(((x - a) * 65536) / (c - a));
      q2 = sat(((x - b) * 65536) / (c - b));
      return sat((q1 * q2) >>> 16);
    endfunction

    // Note one accepted input beat.
    function void note_item(logic act, logic [5:0] r, logic [2:0] c,
                            logic signed [31:0] ev, logic signed [31:0] qp);
      int nr, nc, best, k;
      longint x, d, bestd, x0, x1, x2, w0, w1, w2, v;
      bit err;
      interp_beat_t b;
      if (act == tqi_pkg::ActWrite) begin
        tbl[r*NumCols + c] = longint'(ev);
        written[r*NumCols + c] = 1;
        return;
      end
      nr = eff_rows();
      nc = eff_cols();
      x = longint'(qp);
      best = 0;
      bestd = -1;
      for (int i = 0; i < nr; i++) begin
        d = tbl[i*NumCols] - x;
        if (d < 0) d = -d;
        if (bestd < 0 || d < bestd) begin
          bestd = d;
          best = i;
        end
      end
      if (best < 1) best = 1;
      if (best > nr - 2) best = nr - 2;
      x0 = tbl[(best-1)*NumCols];
      x1 = tbl[best*NumCols];
      x2 = tbl[(best+1)*NumCols];
      err = (x0 == x1) || (x0 == x2) || (x1 == x2);
      w0 = 0; w1 = 0; w2 = 0;
      if (!err) begin
        w0 = lweight(x, x0, x1, x2);
        w1 = lweight(x, x1, x0, x2);
        w2 = lweight(x, x2, x0, x1);
      end
      for (k = 1; k < nc; k++) begin
        v = 0;
        if (!err)
          v = sat(((w0 * tbl[(best-1)*NumCols + k]) >>> 16)
                + ((w1 * tbl[best*NumCols + k]) >>> 16)
                + ((w2 * tbl[(best+1)*NumCols + k]) >>> 16));
        b.col = k[2:0];
        b.val = v[31:0];
        b.last = (k == nc - 1);
        b.err = err;
        awaited.push_back(b);
      end
    endfunction

    function void check_result(interp_beat_t got);
      interp_beat_t exp_b;
      beats_seen++;
      if (got.err) div_err_seen++;
      if (awaited.size() == 0) begin
        $error("result beat with nothing awaited: col %0d value %0d", got.col, got.val);
        errors++;
        return;
      end
      exp_b = awaited.pop_front();
      if (got.col !== exp_b.col) begin
        $error("out_column: expected %0d, got %0d", exp_b.col, got.col);
        errors++;
      end
      if (got.val !== exp_b.val) begin
        $error("out_value: expected %0d, got %0d", exp_b.val, got.val);
        errors++;
      end
      if (got.last !== exp_b.last) begin
        $error("last: expected %0b, got %0b", exp_b.last, got.last);
        errors++;
      end
      if (got.err !== exp_b.err) begin
        $error("div_error: expected %0b, got %0b", exp_b.err, got.err);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i = tqi_pkg::CfgIdxRows;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               action_i = tqi_pkg::ActWrite;
  logic [5:0]         row_i = '0;
  logic [2:0]         column_i = '0;
  logic signed [31:0] entry_value_i = '0;
  logic signed [31:0] query_point_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [2:0]         out_column_o;
  logic signed [31:0] out_value_o;
  logic               last_o;
  logic               div_error_o;

  table_quadratic_interpolator_unit dut (.*);

  lagrange_predictor pred = new();

  int burst_left = 0;
  int n_writes = 0;
  int n_queries = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: runs of ready or stall with random length and polarity.
  int  ready_run = 0;
  bit  ready_mode = 1'b1;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      pred.check_result('{out_column_o, out_value_o, last_o, div_error_o});
    if (ready_run == 0) begin
      ready_run = $urandom_range(1, 30);
      ready_mode = ($urandom % 3) != 0;
    end
    ready_run--;
    out_ready_i <= ready_mode;
  end

  // One input beat; valid stays up across a burst and drops for the gaps.
  task automatic send_item(logic act, logic [5:0] r, logic [2:0] c,
                           logic signed [31:0] ev, logic signed [31:0] qp);
    in_valid_i    <= 1'b1;
    action_i      <= act;
    row_i         <= r;
    column_i      <= c;
    entry_value_i <= ev;
    query_point_i <= qp;
    do @(posedge clk_i); while (!in_ready_o);
    pred.note_item(act, r, c, ev, qp);
    if (act == tqi_pkg::ActWrite) n_writes++;
    else n_queries++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom % 4 != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  endtask

  task automatic write_entry(int r, int c, logic signed [31:0] v);
    send_item(tqi_pkg::ActWrite, r[5:0], c[2:0], v, $urandom);
  endtask

  task automatic query(logic signed [31:0] x);
    send_item(tqi_pkg::ActQuery, 6'($urandom), 3'($urandom), $urandom, x);
  endtask

  // Block idle: no beat outstanding, plus slack for a trailing table write.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pred.awaited.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    pred.set_reg(idx, d);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom % 5)
      0: return $urandom;
      1: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      2: case ($urandom % 4)
           0: return 32'sh7fffffff;
           1: return 32'sh80000000;
           2: return 0;
           default: return -1;
         endcase
      default: return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
    endcase
  endfunction

  // Abscissa for row r: mostly ascending with jitter, sometimes anywhere.
  function automatic logic signed [31:0] abscissa(int r);
    if ($urandom % 8 == 0) return $urandom;
    return r * 32'sh18000 - 32'sh100000 + $signed($urandom_range(0, 16'hffff));
  endfunction

  task automatic fill_region();
    for (int r = 0; r < pred.eff_rows(); r++)
      for (int c = 0; c < pred.eff_cols(); c++)
        if (!pred.written[r*NumCols + c])
          write_entry(r, c, c == 0 ? abscissa(r) : rand_value());
  endtask

  // Random mix inside the current setting; the table region read by a query
  // is always fully written.
  task automatic random_phase(int n_items);
    int r, c;
    logic signed [31:0] x;
    fill_region();
    repeat (n_items) begin
      if ($urandom % 10 < 3) begin
        r = ($urandom % 4 == 0) ? $urandom_range(0, NumRows - 1)
                                : $urandom_range(0, pred.eff_rows() - 1);
        c = $urandom_range(0, NumCols - 1);
        write_entry(r, c, c == 0 ? abscissa(r) : rand_value());
      end else begin
        r = $urandom_range(0, pred.eff_rows() - 1);
        case ($urandom % 6)
          0: x = $urandom;
          1: x = pred.tbl[r*NumCols][31:0];
          default: x = pred.tbl[r*NumCols][31:0] + $signed($urandom_range(0, 18'h3ffff))
                       - 32'sh20000;
        endcase
        query(x);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset setting (3 rows, 1 data column), extreme ordinates and
    // query points, a tie between two rows, then equal node abscissas.
    write_entry(0, 0, 32'sh0);
    write_entry(1, 0, 32'sh10000);
    write_entry(2, 0, 32'sh20000);
    write_entry(0, 1, 32'sh7fffffff);
    write_entry(1, 1, 32'sh80000000);
    write_entry(2, 1, 32'sh0);
    query(32'sh80000000);
    query(32'sh7fffffff);
    query(32'sh18000);          // tie between rows 1 and 2: first wins
    query(32'sh0);
    write_entry(1, 1, 32'sh00030000);
    query(32'sh0c000);
    write_entry(2, 0, 32'sh10000);   // duplicate abscissa
    query(32'sh10000);
    write_entry(2, 0, 32'sh30000);
    query(32'shfffe0000);
    drain();

    // Settings: out-of-range values saturate, extremes included.
    write_reg(tqi_pkg::CfgIdxRows, 32'd0);   write_reg(tqi_pkg::CfgIdxCols, 32'd0);
    random_phase(25);  drain();
    write_reg(tqi_pkg::CfgIdxRows, 32'd5);   write_reg(tqi_pkg::CfgIdxCols, 32'd3);
    random_phase(30);  drain();
    write_reg(tqi_pkg::CfgIdxRows, 32'd20);  write_reg(tqi_pkg::CfgIdxCols, 32'd5);
    random_phase(25);  drain();
    write_reg(tqi_pkg::CfgIdxRows, 32'd64);  write_reg(tqi_pkg::CfgIdxCols, 32'd2);
    random_phase(25);  drain();
    write_reg(tqi_pkg::CfgIdxRows, 32'd3);   write_reg(tqi_pkg::CfgIdxCols, 32'hfffffff9);
    random_phase(25);  drain();
    write_reg(tqi_pkg::CfgIdxRows, 32'hffffffc8); write_reg(tqi_pkg::CfgIdxCols, 32'd1);
    random_phase(25);  drain();
    write_reg(tqi_pkg::CfgIdxRows, 32'd10);  write_reg(tqi_pkg::CfgIdxCols, 32'd4);
    random_phase(25);  drain();
    write_reg(tqi_pkg::CfgIdxRows, 32'd7);   write_reg(tqi_pkg::CfgIdxCols, 32'd15);
    random_phase(25);  drain();

    $display("covered %0d table writes, %0d queries, %0d result beats (%0d with div_error)",
             n_writes, n_queries, pred.beats_seen, pred.div_err_seen);
    if (pred.errors == 0 && pred.awaited.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule
